/* src/skt_pkg.sv */
package skt_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int KEY_W            = 16;
    localparam int VAL_W            = 16;
    localparam int COUNT_W          = 7;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_FIND   = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_COUNT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_DUP     = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RESULT
    } state_t;

endpackage

/* src/sorted_key_table.sv */
// Ordered key/value table of CAPACITY records in a single-port memory. One
// operation (insert, find, delete, count) per beat; in_stall stays high
// until the result is loaded into the output register, which then waits on
// out_stall while the next beat may already be taken. With n records held
// and p the ordered position of the key: count skips the memory; find,
// insert and delete scan linearly from entry 0 up to p; insert then shifts
// entries p..n-1 up by one and delete shifts the entries above p down by one.
// Run time is set by the linear scan and the entry shift, each reading and
// then comparing or writing one entry at a time on the one memory port.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic [skt_pkg::KEY_W-1:0]    key,
    input  logic [skt_pkg::VAL_W-1:0]    record_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [skt_pkg::VAL_W-1:0]    found_value,
    output logic [skt_pkg::COUNT_W-1:0]  entry_count
);
    import skt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = KEY_W + VAL_W;

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 held_reg, held_next;
    logic [VAL_W-1:0]     found_reg, found_next;
    status_t              stat_reg, stat_next;
    logic [CW-1:0]        used_reg, used_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_stat_reg, out_stat_next;
    logic [VAL_W-1:0]     out_found_reg, out_found_next;
    logic [CW-1:0]        out_count_reg, out_count_next;

    logic [DW-1:0]        entries_reg [CAPACITY];
    logic [DW-1:0]        rd_data_reg;
    logic [AW-1:0]        mem_addr;
    logic                 mem_we;
    logic [DW-1:0]        mem_wdata;

    logic [KEY_W-1:0]     rd_key;
    logic [VAL_W-1:0]     rd_val;
    logic [CW-1:0]        idx_inc;
    logic [CW-1:0]        idx_dec;
    logic [CW+COUNT_W-1:0] count_ext;

    assign rd_key  = rd_data_reg[DW-1:VAL_W];
    assign rd_val  = rd_data_reg[VAL_W-1:0];
    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);

    // single-port memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entries_reg[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= entries_reg[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        held_reg      <= held_next;
        found_reg     <= found_next;
        stat_reg      <= stat_next;
        out_stat_reg  <= out_stat_next;
        out_found_reg <= out_found_next;
        out_count_reg <= out_count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        found_next     = found_reg;
        stat_next      = stat_reg;
        used_next      = used_reg;
        out_stat_next  = out_stat_reg;
        out_found_next = out_found_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_addr       = '0;
        mem_we         = 1'b0;
        mem_wdata      = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind_t'(kind);
                    key_next   = key;
                    val_next   = record_value;
                    idx_next   = '0;
                    found_next = '0;
                    stat_next  = STAT_DONE;
                    if (kind_t'(kind) == KIND_COUNT)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end

            S_SRCH_RD:
            begin
                mem_addr = idx_reg[AW-1:0];
                if (idx_reg >= used_reg)
                begin
                    pos_next   = idx_reg;
                    held_next  = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP:
            begin
                if (rd_key < key_reg)
                begin
                    idx_next   = idx_inc;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    pos_next   = idx_reg;
                    held_next  = (rd_key == key_reg);
                    found_next = rd_val;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                found_next = '0;
                unique case (kind_reg)
                    KIND_INSERT:
                    begin
                        if (held_reg)
                        begin
                            stat_next  = STAT_DUP;
                            state_next = S_RESULT;
                        end
                        else if (used_reg == CW'(CAPACITY))
                        begin
                            stat_next  = STAT_FULL;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            idx_next   = used_reg;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    KIND_FIND:
                    begin
                        if (held_reg)
                        begin
                            found_next = found_reg;
                        end
                        else
                        begin
                            stat_next = STAT_MISSING;
                        end
                        state_next = S_RESULT;
                    end
                    KIND_DELETE:
                    begin
                        if (held_reg)
                        begin
                            idx_next   = pos_reg;
                            state_next = S_SHIFT_RD;
                        end
                        else
                        begin
                            stat_next  = STAT_MISSING;
                            state_next = S_RESULT;
                        end
                    end
                    KIND_COUNT:
                    begin
                        state_next = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            S_SHIFT_RD:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    mem_addr = idx_dec[AW-1:0];
                    if (idx_reg > pos_reg)
                    begin
                        state_next = S_SHIFT_WR;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    mem_addr = idx_inc[AW-1:0];
                    if (idx_inc < used_reg)
                    begin
                        state_next = S_SHIFT_WR;
                    end
                    else
                    begin
                        used_next  = used_reg - CW'(1);
                        state_next = S_RESULT;
                    end
                end
            end

            S_SHIFT_WR:
            begin
                mem_addr  = idx_reg[AW-1:0];
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                if (kind_reg == KIND_INSERT)
                begin
                    idx_next = idx_dec;
                end
                else
                begin
                    idx_next = idx_inc;
                end
                state_next = S_SHIFT_RD;
            end

            S_PUT:
            begin
                mem_addr   = pos_reg[AW-1:0];
                mem_we     = 1'b1;
                mem_wdata  = {key_reg, val_reg};
                used_next  = used_reg + CW'(1);
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                // load only when the output slot frees up this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_found_next = found_reg;
                    out_count_next = used_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_ext   = {{COUNT_W{1'b0}}, out_count_reg};
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_stat_reg;
    assign found_value = out_found_reg;
    assign entry_count = count_ext[COUNT_W-1:0];

endmodule
